@@ design/nra_pkg.sv @@
// Package: shared types and constants for the neighbourhood rewrite automaton.
package nra_pkg;
    localparam int GRID_W_DEF = 64;
    localparam int GRID_H_DEF = 64;
    localparam int SLOTS_DEF  = 16;
    localparam logic [7:0] WILDCARD = 8'd42;
    localparam int CELLS_IN_RULE = 9;

    typedef enum logic [2:0] {
        REQ_WRITE  = 3'd0,
        REQ_READ   = 3'd1,
        REQ_LOAD   = 3'd2,
        REQ_UPDATE = 3'd3,
        REQ_SWEEP  = 3'd4,
        REQ_BLOB   = 3'd5,
        REQ_NOP6   = 3'd6,
        REQ_NOP7   = 3'd7
    } t_req;

    localparam logic CFG_RULES  = 1'b0;
    localparam logic CFG_RADIUS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_UPD_START,
        ST_UPD_OWN,
        ST_UPD_RULE,
        ST_UPD_MATCH,
        ST_UPD_WRITE,
        ST_SWEEP_NEXT,
        ST_BLOB,
        ST_DONE
    } t_state;
endpackage

@@ design/nra_if.sv @@
// Interfaces: request, result and configuration channels.
interface nra_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] cell_value;
    logic [3:0] rule_slot;
    logic [2:0] rule_row;
    logic [7:0] rule_owner;
    logic [7:0] pattern_left;
    logic [7:0] pattern_middle;
    logic [7:0] pattern_right;
    modport source (output valid, req_type, pos_x, pos_y, cell_value, rule_slot, rule_row,
                    rule_owner, pattern_left, pattern_middle, pattern_right, input ready);
    modport sink (input valid, req_type, pos_x, pos_y, cell_value, rule_slot, rule_row,
                  rule_owner, pattern_left, pattern_middle, pattern_right, output ready);
endinterface

interface nra_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_value;
    logic       rule_fired;
    modport source (output valid, read_value, rule_fired, input ready);
    modport sink (input valid, read_value, rule_fired, output ready);
endinterface

interface nra_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [5:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/nra_grid_mem.sv @@
// Grid memory: one synchronous port, registered read data.
module nra_grid_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ design/nra_rule_mem.sv @@
// Rule memory: patterns and owners, synchronous, registered reads.
module nra_rule_mem #(
    parameter int SLOTS = 16,
    parameter int SW    = 4,
    parameter int PW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [PW-1:0] i_waddr,
    input  logic [23:0]   i_wpat,
    input  logic [SW-1:0] i_wslot,
    input  logic [7:0]    i_wown,
    input  logic [PW-1:0] i_raddr,
    input  logic [SW-1:0] i_rslot,
    output logic [23:0]   o_pat,
    output logic [7:0]    o_own
);
    logic [23:0] r_pat [SLOTS*6];
    logic [7:0]  r_own [SLOTS];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pat[i_waddr] <= i_wpat;
            r_own[i_wslot] <= i_wown;
        end
        o_pat <= r_pat[i_raddr];
        o_own <= r_own[i_rslot];
    end
endmodule

@@ design/neighbourhood_rewrite_automaton_top.sv @@
// Top level: request decoder, sequencer for update, sweep and blob, and memories.
// Update walks the rules in slot order, skipping rules of another owner; the first rule that
// fires ends the walk. Sweep updates every cell, rows from the last up, even columns first.
// One request at a time: the next request can transfer in the cycle after the result transfers.
// Synchronous active-low reset clears control, sets rule count 0 and disc radius 4; memories hold.
module neighbourhood_rewrite_automaton_top
    import nra_pkg::*;
#(
    parameter int GRID_WIDTH  = nra_pkg::GRID_W_DEF,
    parameter int GRID_HEIGHT = nra_pkg::GRID_H_DEF,
    parameter int RULE_SLOTS  = nra_pkg::SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    nra_req_if.sink   i_req,
    nra_rsp_if.source o_rsp,
    nra_cfg_if.sink   i_cfg
);
    localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);
    localparam int SW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int PW = $clog2(RULE_SLOTS * 6);
    localparam int CW = SW + 1;

    // Signed coordinates wide enough for the 6-bit inputs and grid + blob offsets.
    localparam int CDW = ((XW > YW) ? XW : YW) + 3 > 9 ? ((XW > YW) ? XW : YW) + 3 : 9;
    typedef logic signed [CDW-1:0] t_coord;

    t_state r_state, n_state;
    logic [4:0] r_rules;
    logic [5:0] r_radius;

    logic [2:0] r_req;
    t_coord     r_x, n_x, r_y, n_y;
    logic [7:0] r_val;
    logic [CW-1:0] r_slot, n_slot;      // rule index under test
    logic [3:0] r_k, n_k;               // neighbourhood position 0..8
    logic [7:0] r_own_cell, n_own_cell;
    logic       r_fired, n_fired;
    logic       r_sfired, n_sfired;     // sweep-wide fired flag
    logic       r_odd, n_odd;           // sweep half-row phase
    logic       r_rdv, n_rdv;           // grid read issued last cycle
    logic [7:0] r_out_rd, n_out_rd;
    logic       r_out_f, n_out_f;
    logic       r_ovalid, n_ovalid;
    t_coord     r_dx, n_dx, r_dy, n_dy;
    logic signed [13:0] r_r2;

    logic          g_we;
    logic [AW-1:0] g_addr;
    logic [7:0]    g_wdata, g_rdata;
    logic          p_we;
    logic [PW-1:0] p_raddr;
    logic [23:0]   p_rdata;
    logic [7:0]    o_rdata;

    logic [CW-1:0] n_lim;
    assign n_lim = (32'(r_rules) > RULE_SLOTS) ? CW'(RULE_SLOTS) : CW'(r_rules);

    // Neighbourhood offsets for position k.
    logic [1:0] k_row, k_col;
    always_comb begin
        unique case (r_k)
            4'd0, 4'd1, 4'd2: k_row = 2'd0;
            4'd3, 4'd4, 4'd5: k_row = 2'd1;
            default:          k_row = 2'd2;
        endcase
        unique case (r_k)
            4'd0, 4'd3, 4'd6: k_col = 2'd0;
            4'd1, 4'd4, 4'd7: k_col = 2'd1;
            default:          k_col = 2'd2;
        endcase
    end
    t_coord nb_x, nb_y;
    logic   nb_in;
    assign nb_x  = r_x + t_coord'(k_col) - t_coord'(1);
    assign nb_y  = r_y + t_coord'(k_row) - t_coord'(1);
    assign nb_in = nb_x >= 0 && nb_x < t_coord'(GRID_WIDTH)
                && nb_y >= 0 && nb_y < t_coord'(GRID_HEIGHT);

    logic [7:0] pat_b;
    always_comb begin
        unique case (k_col)
            2'd0:    pat_b = p_rdata[23:16];
            2'd1:    pat_b = p_rdata[15:8];
            default: pat_b = p_rdata[7:0];
        endcase
    end

    function automatic logic [AW-1:0] cell_addr(input t_coord x, input t_coord y);
        logic [AW+CDW-1:0] a;
        a = (AW+CDW)'(unsigned'(y)) * (AW+CDW)'(GRID_WIDTH) + (AW+CDW)'(unsigned'(x));
        return a[AW-1:0];
    endfunction

    logic c_in;
    assign c_in = r_x >= 0 && r_x < t_coord'(GRID_WIDTH) && r_y >= 0
               && r_y < t_coord'(GRID_HEIGHT);

    // Blob position.
    t_coord bx, by;
    logic   b_hit;
    logic signed [2*CDW-1:0] d2;
    assign bx = r_x + r_dx;
    assign by = r_y + r_dy;
    assign d2 = r_dx * r_dx + r_dy * r_dy;
    assign b_hit = d2 < (2*CDW)'(r_r2) && bx >= 0 && bx < t_coord'(GRID_WIDTH)
                && by >= 0 && by < t_coord'(GRID_HEIGHT);

    logic acc;
    assign i_req.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign acc = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign p_we = acc && i_req.req_type == REQ_LOAD && 32'(i_req.rule_slot) < RULE_SLOTS
               && i_req.rule_row < 3'd6;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.rule_fired = r_out_f;

    logic [PW+3:0] pa;
    assign pa = (PW+4)'(r_slot) * (PW+4)'(6) + (PW+4)'(k_row)
              + ((r_state == ST_UPD_WRITE) ? (PW+4)'(3) : (PW+4)'(0));

    logic [PW+3:0] pw;
    assign pw = (PW+4)'(i_req.rule_slot) * (PW+4)'(6) + (PW+4)'(i_req.rule_row);

    always_comb begin
        n_state = r_state; n_x = r_x; n_y = r_y; n_slot = r_slot; n_k = r_k;
        n_own_cell = r_own_cell; n_fired = r_fired; n_sfired = r_sfired; n_odd = r_odd;
        n_out_rd = r_out_rd; n_out_f = r_out_f; n_ovalid = r_ovalid;
        n_dx = r_dx; n_dy = r_dy; n_rdv = 1'b0;
        g_we = 1'b0; g_addr = cell_addr(r_x, r_y); g_wdata = r_val;
        p_raddr = pa[PW-1:0];
        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_x = t_coord'(i_req.pos_x); n_y = t_coord'(i_req.pos_y);
                    n_out_rd = 8'd0; n_out_f = 1'b0;
                    unique case (i_req.req_type)
                        REQ_WRITE: begin
                            g_addr = cell_addr(t_coord'(i_req.pos_x), t_coord'(i_req.pos_y));
                            g_wdata = i_req.cell_value;
                            g_we = 32'(i_req.pos_x) < GRID_WIDTH
                                && 32'(i_req.pos_y) < GRID_HEIGHT;
                            n_ovalid = 1'b1;
                        end
                        REQ_READ:   n_state = ST_RD_WAIT;
                        REQ_UPDATE: begin n_state = ST_UPD_START; n_sfired = 1'b0; end
                        REQ_SWEEP: begin
                            n_x = '0; n_y = t_coord'(GRID_HEIGHT - 1); n_odd = 1'b0;
                            n_sfired = 1'b0; n_state = ST_UPD_START;
                        end
                        REQ_BLOB: begin
                            n_dx = -t_coord'(r_radius); n_dy = -t_coord'(r_radius);
                            n_state = (r_radius == 6'd0) ? ST_DONE : ST_BLOB;
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                // Issue read this cycle; data valid in ST_DONE via r_rdv.
                n_rdv = 1'b1; n_state = ST_DONE;
            end
            ST_UPD_START: begin
                n_slot = '0; n_k = '0; n_fired = 1'b0;
                if (c_in) begin n_rdv = 1'b1; n_state = ST_UPD_OWN; end
                else n_state = (r_req == REQ_SWEEP) ? ST_SWEEP_NEXT : ST_DONE;
            end
            ST_UPD_OWN: begin
                n_own_cell = g_rdata;
                n_state = ST_UPD_RULE;
            end
            ST_UPD_RULE: begin
                // Present slot to owner memory; compare next cycle.
                n_k = '0;
                if (r_slot >= n_lim)
                    n_state = (r_req == REQ_SWEEP) ? ST_SWEEP_NEXT : ST_DONE;
                else begin
                    n_state = ST_UPD_MATCH; n_rdv = 1'b0;
                end
            end
            ST_UPD_MATCH: begin
                // r_rdv marks that pattern and cell data for r_k are valid.
                g_addr = cell_addr(nb_x, nb_y);
                if (!r_rdv) begin
                    if (o_rdata != r_own_cell) begin
                        n_slot = r_slot + 1'b1; n_state = ST_UPD_RULE;
                    end else n_rdv = 1'b1;
                end else if (pat_b != WILDCARD && (!nb_in || g_rdata != pat_b)) begin
                    n_slot = r_slot + 1'b1; n_state = ST_UPD_RULE;
                end else if (r_k == 4'd8) begin
                    n_k = '0; n_state = ST_UPD_WRITE; n_rdv = 1'b0;
                end else begin
                    n_k = r_k + 1'b1; n_rdv = 1'b0;
                end
            end
            ST_UPD_WRITE: begin
                g_addr = cell_addr(nb_x, nb_y);
                g_wdata = pat_b;
                if (!r_rdv) n_rdv = 1'b1;
                else begin
                    g_we = pat_b != WILDCARD && nb_in;
                    n_rdv = 1'b0;
                    if (r_k == 4'd8) begin
                        n_fired = 1'b1; n_sfired = 1'b1;
                        n_state = (r_req == REQ_SWEEP) ? ST_SWEEP_NEXT : ST_DONE;
                    end else n_k = r_k + 1'b1;
                end
            end
            ST_SWEEP_NEXT: begin
                n_state = ST_UPD_START;
                if (r_x + t_coord'(2) < t_coord'(GRID_WIDTH)) n_x = r_x + t_coord'(2);
                else if (!r_odd) begin n_odd = 1'b1; n_x = t_coord'(1); end
                else begin
                    n_odd = 1'b0; n_x = '0;
                    if (r_y == 0) begin n_state = ST_DONE; n_fired = r_sfired; end
                    else n_y = r_y - t_coord'(1);
                end
                if (!r_odd && r_x + t_coord'(2) >= t_coord'(GRID_WIDTH) && GRID_WIDTH < 2)
                    n_state = ST_SWEEP_NEXT;
            end
            ST_BLOB: begin
                g_addr = cell_addr(bx, by);
                g_we = b_hit;
                if (r_dy + t_coord'(1) < t_coord'(r_radius)) n_dy = r_dy + t_coord'(1);
                else begin
                    n_dy = -t_coord'(r_radius);
                    if (r_dx + t_coord'(1) < t_coord'(r_radius)) n_dx = r_dx + t_coord'(1);
                    else n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free, then post the result.
                if (!r_ovalid) begin
                    n_out_rd = (r_req == REQ_READ && r_rdv) ? g_rdata : 8'd0;
                    n_out_f = (r_req == REQ_UPDATE || r_req == REQ_SWEEP) ? r_fired : 1'b0;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end else n_rdv = r_rdv;
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_DONE && r_req == REQ_READ && !c_in) n_out_rd = 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ovalid <= 1'b0; r_rules <= 5'd0; r_radius <= 6'd4;
            r_rdv <= 1'b0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_rdv <= n_rdv;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_RULES:  r_rules  <= i_cfg.data[4:0];
                    CFG_RADIUS: r_radius <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_slot <= n_slot; r_k <= n_k; r_own_cell <= n_own_cell;
        r_fired <= n_fired; r_sfired <= n_sfired; r_odd <= n_odd; r_out_rd <= n_out_rd;
        r_out_f <= n_out_f; r_dx <= n_dx; r_dy <= n_dy;
        r_r2 <= 14'(r_radius) * 14'(r_radius);
        if (acc) begin r_req <= i_req.req_type; r_val <= i_req.cell_value; end
    end

    nra_grid_mem #(.DEPTH(GRID_WIDTH * GRID_HEIGHT), .AW(AW)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_addr(g_addr), .i_wdata(g_wdata), .o_rdata(g_rdata)
    );

    nra_rule_mem #(.SLOTS(RULE_SLOTS), .SW(SW), .PW(PW)) u_rules (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(pw[PW-1:0]),
        .i_wpat({i_req.pattern_left, i_req.pattern_middle, i_req.pattern_right}),
        .i_wslot(SW'(i_req.rule_slot)), .i_wown(i_req.rule_owner),
        .i_raddr(p_raddr), .i_rslot(r_slot[SW-1:0]), .o_pat(p_rdata), .o_own(o_rdata)
    );
endmodule
